[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define DBSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define DBSQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/dbsq_pkg.sv]
// ---------------------------------------------------------------------------
// dbsq_pkg
// Types, codes and defaults for the display buffer slot queue.
// ---------------------------------------------------------------------------
package dbsq_pkg;

  // Default number of slots
  localparam int SLOT_COUNT_DEF = 16;

  // Operation codes
  localparam logic [2:0] OP_REGISTER = 3'd0;
  localparam logic [2:0] OP_DEQUEUE  = 3'd1;
  localparam logic [2:0] OP_QUEUE    = 3'd2;
  localparam logic [2:0] OP_ACQUIRE  = 3'd3;
  localparam logic [2:0] OP_FLUSH    = 3'd4;

  // Result status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_NONE = 2'd1;
  localparam logic [1:0] STATUS_BAD  = 2'd2;

  // Request payload
  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  slot_index;
    logic [31:0] buffer_handle;
    logic [63:0] frame_info;
  } dbsq_req_t;

  // Response payload
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_out;
    logic [63:0] frame_info_out;
    logic        event_level;
  } dbsq_rsp_t;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } dbsq_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
  } dbsq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } dbsq_stat_t;

endpackage

[rtl/display_buffer_slot_queue_top.sv]
// ---------------------------------------------------------------------------
// display_buffer_slot_queue_top
// Buffer queue over a fixed set of display slots: register, dequeue free
// slot, queue, acquire oldest and flush, one response per request.
// ---------------------------------------------------------------------------
//   channel   handshake              payload
//   request   req_valid / req_ready  req : dbsq_req_t
//   response  rsp_valid / rsp_ready  rsp : dbsq_rsp_t
//
// Each request is taken in the idle state, which reads the queue head memory,
// then applied in the execute state, which loads the response register.
// The request side stays ready while an earlier response waits; a request
// then holds in the apply cycle until that response transfers.
// Reset is synchronous; after it no slot is ready, the queue is empty and
// the event flag is signalled.
// ---------------------------------------------------------------------------
module display_buffer_slot_queue_top import dbsq_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  dbsq_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output dbsq_rsp_t rsp
);

  dbsq_cmd_t  cmd;
  dbsq_stat_t stat;

  // Sequencer
  dbsq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Slot state and queue
  dbsq_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

[rtl/dbsq_ctrl.sv]
// ---------------------------------------------------------------------------
// dbsq_ctrl
// Two-state sequencer: take a request, then apply it once the response
// register can load.
// ---------------------------------------------------------------------------
module dbsq_ctrl import dbsq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  dbsq_stat_t stat,
  output dbsq_cmd_t  cmd
);

  dbsq_state_t state;
  dbsq_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req_ready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      S_EXEC: begin
        cmd.execute = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

[rtl/dbsq_datapath.sv]
// ---------------------------------------------------------------------------
// dbsq_datapath
// Slot flags, queue memories and pointers, event flag and response register.
// ---------------------------------------------------------------------------
module dbsq_datapath import dbsq_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  dbsq_req_t  req,
  input  dbsq_cmd_t  cmd,
  output dbsq_stat_t stat,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output dbsq_rsp_t  rsp
);

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int FW = $clog2(SLOT_COUNT + 1);

  // Advance a queue pointer with wrap at the slot count
  function automatic logic [SW-1:0] wrap_next(input logic [SW-1:0] p);
    return (p == SW'(SLOT_COUNT - 1)) ? '0 : SW'(p + 1'b1);
  endfunction

  dbsq_req_t             op_q;
  logic [SLOT_COUNT-1:0] slot_ready, slot_ready_next;
  logic [SLOT_COUNT-1:0] slot_in_queue, slot_in_queue_next;
  logic [SW-1:0]         fifo_head, fifo_head_next;
  logic [SW-1:0]         fifo_tail, fifo_tail_next;
  logic [FW-1:0]         fifo_fill, fifo_fill_next;
  logic                  event_flag, event_flag_next;

  logic [SW-1:0]         fifo_slot_mem [SLOT_COUNT];
  logic [63:0]           fifo_info_mem [SLOT_COUNT];
  logic [SW-1:0]         rd_slot;
  logic [63:0]           rd_info;

  logic                  in_range;
  logic [SW-1:0]         slot_sel;
  logic [SLOT_COUNT-1:0] free_mask;
  logic                  free_any;
  logic                  free_second;
  logic [SW-1:0]         found_idx;
  logic                  push;
  dbsq_rsp_t             res;

  assign stat.out_free = !rsp_valid || rsp_ready;

  // Hold the request; read the queue head while it is taken
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= req;
      rd_slot <= fifo_slot_mem[fifo_head];
      rd_info <= fifo_info_mem[fifo_head];
    end
  end

  // Write the queue memories at the tail on a push
  always_ff @(posedge clk) begin
    if (cmd.execute && push) begin
      fifo_slot_mem[fifo_tail] <= slot_sel;
      fifo_info_mem[fifo_tail] <= op_q.frame_info;
    end
  end

  // Slot decode
  assign in_range = 7'(op_q.slot_index) < 7'(SLOT_COUNT);
  assign slot_sel = SW'(op_q.slot_index);

  // Lowest free slot and whether a second one exists
  assign free_mask   = slot_ready & ~slot_in_queue;
  assign free_any    = |free_mask;
  assign free_second = |(free_mask & (free_mask - 1'b1));

  always_comb begin
    found_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (free_mask[i]) found_idx = SW'(i);
    end
  end

  // Apply the operation
  always_comb begin
    res                = '0;
    slot_ready_next    = slot_ready;
    slot_in_queue_next = slot_in_queue;
    fifo_head_next     = fifo_head;
    fifo_tail_next     = fifo_tail;
    fifo_fill_next     = fifo_fill;
    event_flag_next    = event_flag;
    push               = 1'b0;
    res.status         = STATUS_OK;
    case (op_q.opcode)
      OP_REGISTER: begin
        if (!in_range) begin
          res.status = STATUS_BAD;
        end else begin
          slot_ready_next[slot_sel] = 1'b1;
        end
      end
      OP_DEQUEUE: begin
        if (!free_any) begin
          res.status = STATUS_NONE;
        end else begin
          res.slot_out = 4'(found_idx);
        end
        if (!free_second) event_flag_next = 1'b0;
      end
      OP_QUEUE: begin
        if (!in_range || !slot_ready[slot_sel] || slot_in_queue[slot_sel] ||
            fifo_fill >= FW'(SLOT_COUNT)) begin
          res.status = STATUS_BAD;
        end else begin
          push                         = 1'b1;
          fifo_tail_next               = wrap_next(fifo_tail);
          fifo_fill_next               = FW'(fifo_fill + 1'b1);
          slot_in_queue_next[slot_sel] = 1'b1;
        end
      end
      OP_ACQUIRE: begin
        if (fifo_fill == '0) begin
          res.status = STATUS_NONE;
        end else begin
          res.slot_out                = 4'(rd_slot);
          res.frame_info_out          = rd_info;
          slot_in_queue_next[rd_slot] = 1'b0;
          fifo_head_next              = wrap_next(fifo_head);
          fifo_fill_next              = FW'(fifo_fill - 1'b1);
          event_flag_next             = 1'b1;
        end
      end
      OP_FLUSH: begin
        slot_in_queue_next = '0;
        fifo_head_next     = fifo_tail;
        fifo_fill_next     = '0;
        event_flag_next    = 1'b1;
      end
      default: ;
    endcase
    res.event_level = event_flag_next;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_ready    <= '0;
      slot_in_queue <= '0;
      fifo_head     <= '0;
      fifo_tail     <= '0;
      fifo_fill     <= '0;
      event_flag    <= 1'b1;
      rsp_valid     <= 1'b0;
    end else begin
      if (cmd.execute) begin
        slot_ready    <= slot_ready_next;
        slot_in_queue <= slot_in_queue_next;
        fifo_head     <= fifo_head_next;
        fifo_tail     <= fifo_tail_next;
        fifo_fill     <= fifo_fill_next;
        event_flag    <= event_flag_next;
        rsp_valid     <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (cmd.execute) rsp <= res;
  end

endmodule

[rtl/dbsq_checker.sv]
// ---------------------------------------------------------------------------
// dbsq_checker
// Port-level checks for the display buffer slot queue.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dbsq_checker import dbsq_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input dbsq_req_t req,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input dbsq_rsp_t rsp
);

  // No response right after reset
  `DBSQ_ASSERT_RST(a_rst_idle, rst |=> !rsp_valid, "response valid after reset")

  // One request at a time: the apply cycle follows every transfer
  `DBSQ_ASSERT(a_one_at_time, req_valid && req_ready |=> !req_ready, "request taken back to back")

  // A refused or empty result carries no slot and no frame info
  `DBSQ_ASSERT(a_fail_zero, rsp_valid && rsp.status != STATUS_OK |-> rsp.slot_out == '0 && rsp.frame_info_out == '0, "failed result carries data")

  // A stalled response holds
  `DBSQ_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "stalled response changed")

endmodule

bind display_buffer_slot_queue_top dbsq_checker u_dbsq_checker (.*);
